// ===== rtl/lkv_pkg.sv =====
package lkv_pkg;

  localparam int MaxEntries = 16;
  localparam int KeyBits    = 32;
  localparam int ValueBits  = 32;
  localparam int IdxBits    = $clog2(MaxEntries);
  localparam int CntBits    = $clog2(MaxEntries + 1);
  localparam int CapBits    = 5;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_SET = 1'b1;

  typedef struct packed {
    logic                        opcode;
    logic signed [KeyBits-1:0]   lookup_key;
    logic signed [ValueBits-1:0] store_value;
  } lkv_in_t;

  typedef struct packed {
    logic                        found;
    logic signed [ValueBits-1:0] read_value;
    logic                        newly_inserted;
    logic [4:0]                  occupancy;
    logic                        is_full;
  } lkv_out_t;

endpackage

// ===== rtl/lru_key_value_cache_top.sv =====
// LRU key-value cache: a fully associative store of 16 key/value words with
// least-recently-used replacement. Each input word is a get or a set; each
// produces exactly one result word with found, read value, an inserted flag,
// the occupancy and a full flag. Keys, valid bits and recency ranks sit in
// flops so all entries compare in parallel; the values sit in a synchronous
// RAM with a registered read. Each item passes a lookup step that resolves
// hit/victim, updates ranks and writes the value, and a read step that
// returns the RAM data. A new item is not taken while a read is in flight;
// it is taken once the result register is free or being drained by the
// consumer. The capacity register may be written only while idle;
// values 0 and above 16 act as 1 and 16.
module lru_key_value_cache_top (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  lkv_pkg::lkv_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output lkv_pkg::lkv_out_t out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [4:0]       cfg_data
);
  import lkv_pkg::*;

  logic [CapBits-1:0]   cap_r;
  logic [KeyBits-1:0]   key_r [MaxEntries];
  logic [MaxEntries-1:0] vld_r;
  logic [IdxBits-1:0]   rank_r [MaxEntries];
  logic [CntBits-1:0]   cnt_r;

  // Read-step context: a value read is in flight.
  logic                 rd_pend_r;
  logic                 rd_hit_r;
  lkv_out_t             res_r;
  logic                 res_vld_r;

  logic                 accept;
  logic [CntBits-1:0]   cap_eff;
  logic [KeyBits-1:0]   key_in;
  logic [MaxEntries-1:0] hit_vec;
  logic                 hit;
  logic [IdxBits-1:0]   hit_idx;
  logic [IdxBits-1:0]   free_idx;
  logic                 free_any;
  logic [IdxBits-1:0]   lru_idx;
  logic                 evict;
  logic [IdxBits-1:0]   tgt_idx;
  logic                 ins;
  logic [CntBits-1:0]   cnt_nxt;
  logic [ValueBits-1:0] ram_rd;

  // Take a word only when nothing is in flight and the result slot is free.
  assign in_stall  = rd_pend_r | (res_vld_r & out_stall);
  assign accept    = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;
  assign key_in    = in_data.lookup_key;

  always_comb begin
    if (cap_r == '0) begin
      cap_eff = CntBits'(1);
    end else if (cap_r > CapBits'(MaxEntries)) begin
      cap_eff = CntBits'(MaxEntries);
    end else begin
      cap_eff = CntBits'(cap_r);
    end
  end

  // Parallel compare, first free slot, oldest valid entry.
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    free_any = 1'b0;
    lru_idx  = '0;
    for (int i = 0; i < MaxEntries; i++) begin
      hit_vec[i] = vld_r[i] & (key_r[i] == key_in);
      if (hit_vec[i]) hit_idx = IdxBits'(i);
      if (vld_r[i] && rank_r[i] == IdxBits'(cnt_r - CntBits'(1))) lru_idx = IdxBits'(i);
    end
    for (int i = MaxEntries - 1; i >= 0; i--) begin
      if (!vld_r[i]) begin
        free_idx = IdxBits'(i);
        free_any = 1'b1;
      end
    end
  end

  assign hit     = |hit_vec;
  assign ins     = (in_data.opcode == OP_SET) & ~hit;
  assign evict   = ins & ((cnt_r >= cap_eff) | ~free_any);
  assign tgt_idx = hit ? hit_idx : (evict ? lru_idx : free_idx);
  assign cnt_nxt = (ins & ~evict) ? cnt_r + CntBits'(1) : cnt_r;

  lkv_ram #(.Width(ValueBits), .Depth(MaxEntries)) u_val_ram (
    .clk     (clk),
    .wr_en   (accept & (in_data.opcode == OP_SET)),
    .wr_addr (tgt_idx),
    .wr_data (in_data.store_value),
    .rd_addr (tgt_idx),
    .rd_data (ram_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r     <= CapBits'(16);
      vld_r     <= '0;
      cnt_r     <= '0;
      rd_pend_r <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) cap_r <= cfg_data;
      if (res_vld_r && !out_stall) res_vld_r <= 1'b0;
      if (accept) begin
        // Promote the target; entries more recent than it age by one (a fresh insert ages every valid entry).
        // A get that misses leaves the ranks alone.
        if (hit || ins) begin
          for (int i = 0; i < MaxEntries; i++) begin
            if (vld_r[i] && IdxBits'(i) != tgt_idx &&
                ((ins && !evict) || rank_r[i] < rank_r[tgt_idx])) begin
              rank_r[i] <= rank_r[i] + IdxBits'(1);
            end
          end
          rank_r[tgt_idx] <= '0;
        end
        if (ins) begin
          key_r[tgt_idx] <= key_in;
          vld_r[tgt_idx] <= 1'b1;
        end
        cnt_r                  <= cnt_nxt;
        rd_pend_r              <= 1'b1;
        rd_hit_r               <= hit & (in_data.opcode == OP_GET);
        res_r.found            <= hit & (in_data.opcode == OP_GET);
        res_r.newly_inserted   <= ins;
        res_r.occupancy        <= 5'(cnt_nxt);
        res_r.is_full          <= cnt_nxt >= cap_eff;
      end
      if (rd_pend_r) begin
        // Attach the value read and present the word.
        rd_pend_r        <= 1'b0;
        res_vld_r        <= 1'b1;
        res_r.read_value <= rd_hit_r ? ram_rd : '0;
      end
    end
  end

  assign out_valid = res_vld_r;
  assign out_data  = res_r;

  a_cnt_vld : assert property (@(posedge clk) disable iff (!rst_n)
    CntBits'($countones(vld_r)) == cnt_r) else $error("count mismatch");
  a_one_inflight : assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |=> !rd_pend_r) else $error("overlapping reads");
  a_found_get : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.found && out_data.newly_inserted)) else $error("bad flags");
  a_occ_range : assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntBits'(MaxEntries)) else $error("count overflow");

endmodule

// ===== rtl/lkv_ram.sv =====
module lkv_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== verif/tb_lru_key_value_cache_top.sv =====
module tb_lru_key_value_cache_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lkv_pkg::*;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  lkv_in_t    in_data;
  logic       out_valid;
  logic       out_stall;
  lkv_out_t   out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [4:0] cfg_data;

  lru_key_value_cache_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the cache: keys, values, valid bits, recency ranks
  // (0 = most recent), occupancy and the capacity register.
  logic [KeyBits-1:0]   shadow_key   [MaxEntries];
  logic [ValueBits-1:0] shadow_val   [MaxEntries];
  logic                 shadow_vld   [MaxEntries];
  int unsigned          shadow_rank  [MaxEntries];
  int unsigned          shadow_count;
  logic [4:0]           shadow_cap;

  lkv_in_t  pending_words[$];   // words waiting to be offered
  lkv_out_t expected_results[$]; // predicted results, oldest first

  int  error_count;
  int  words_taken;
  bit  in_taken;      // set at the rising edge that accepts an input word
  int  send_gap;
  int  hold_cycles;
  bit  long_hold_done;
  bit  no_idle;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #(8 * 2000000);
    $display("Regression FAIL");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("ERROR @%0t: %s got %0h want %0h", $realtime, what, got, want);
    error_count++;
  endtask

  function automatic int unsigned eff_capacity();
    if (shadow_cap == 0) return 1;
    if (shadow_cap > MaxEntries) return MaxEntries;
    return shadow_cap;
  endfunction

  // Make entry idx the most recent; entries that were more recent age by one.
  function automatic void promote_entry(int idx);
    int unsigned r;
    r = shadow_rank[idx];
    for (int i = 0; i < MaxEntries; i++)
      if (shadow_vld[i] && i != idx && shadow_rank[i] < r) shadow_rank[i]++;
    shadow_rank[idx] = 0;
  endfunction

  // Apply one get/set to the shadow cache and return the result it yields.
  function automatic lkv_out_t cache_access(lkv_in_t w);
    lkv_out_t    r;
    int          hit;
    int          slot;
    int unsigned best;
    int unsigned cap;
    r = '0;
    hit = -1;
    cap = eff_capacity();
    for (int i = 0; i < MaxEntries; i++)
      if (hit < 0 && shadow_vld[i] && shadow_key[i] == w.lookup_key) hit = i;
    if (w.opcode == OP_GET) begin
      if (hit >= 0) begin
        r.found = 1'b1;
        r.read_value = shadow_val[hit];
        promote_entry(hit);
      end
    end else if (hit >= 0) begin
      shadow_val[hit] = w.store_value;
      promote_entry(hit);
    end else begin
      r.newly_inserted = 1'b1;
      slot = -1;
      best = 0;
      if (shadow_count >= cap) begin
        // Evict the least recent entry in place.
        for (int i = 0; i < MaxEntries; i++)
          if (shadow_vld[i] && (slot < 0 || shadow_rank[i] > best)) begin
            slot = i;
            best = shadow_rank[i];
          end
        shadow_key[slot] = w.lookup_key;
        shadow_val[slot] = w.store_value;
        promote_entry(slot);
      end else begin
        for (int i = 0; i < MaxEntries; i++)
          if (slot < 0 && !shadow_vld[i]) slot = i;
        for (int i = 0; i < MaxEntries; i++)
          if (shadow_vld[i]) shadow_rank[i]++;
        shadow_vld[slot]  = 1'b1;
        shadow_key[slot]  = w.lookup_key;
        shadow_val[slot]  = w.store_value;
        shadow_rank[slot] = 0;
        shadow_count++;
      end
    end
    r.occupancy = shadow_count[4:0];
    r.is_full   = (shadow_count >= cap);
    return r;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (no_idle || p < 55) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  // Sample both handshakes at the rising edge: predict on input accept,
  // check on output accept, track register writes.
  always @(posedge clk) begin
    lkv_out_t want;
    in_taken = 1'b0;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) shadow_cap = cfg_data;
      if (in_valid && !in_stall) begin
        in_taken = 1'b1;
        words_taken++;
        expected_results.push_back(cache_access(in_data));
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result word", 32'h1, 32'h0);
        end else begin
          want = expected_results.pop_front();
          if (out_data.found !== want.found)
            report_mismatch("found", out_data.found, want.found);
          if (out_data.read_value !== want.read_value)
            report_mismatch("read_value", out_data.read_value, want.read_value);
          if (out_data.newly_inserted !== want.newly_inserted)
            report_mismatch("newly_inserted", out_data.newly_inserted,
                            want.newly_inserted);
          if (out_data.occupancy !== want.occupancy)
            report_mismatch("occupancy", out_data.occupancy, want.occupancy);
          if (out_data.is_full !== want.is_full)
            report_mismatch("is_full", out_data.is_full, want.is_full);
        end
      end
    end
  end

  // Sender: hold a stalled word, otherwise advance after a random gap.
  always @(negedge clk) begin
    if (rst_n && !(in_valid && !in_taken)) begin
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_words.size() != 0) begin
        in_data  <= pending_words.pop_front();
        in_valid <= 1'b1;
        send_gap <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, and once a long hold-off so the input backs up.
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_cycles > 0) begin
        out_stall   <= 1'b1;
        hold_cycles <= hold_cycles - 1;
      end else if (!long_hold_done && words_taken >= 300) begin
        long_hold_done = 1'b1;
        out_stall   <= 1'b1;
        hold_cycles <= 150;
      end else if (no_idle) begin
        out_stall <= 1'b0;
      end else if ($urandom_range(99) < 3) begin
        out_stall   <= 1'b1;
        hold_cycles <= $urandom_range(25, 6);
      end else begin
        out_stall <= ($urandom_range(99) < 25);
      end
    end
  end

  function automatic lkv_in_t make_word(logic op, logic [31:0] key, logic [31:0] val);
    lkv_in_t w;
    w.opcode      = op;
    w.lookup_key  = key;
    w.store_value = val;
    return w;
  endfunction

  // Drain everything in flight, then let the pipeline settle.
  task automatic wait_idle();
    while (pending_words.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [4:0] cap);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly a small key set sized to the capacity so hits, updates and
  // evictions are frequent; the rest are full-range keys.
  task automatic queue_random_phase(input int n);
    logic [31:0] key_set[];
    int          set_size;
    set_size = eff_capacity() + 3;
    key_set = new[set_size];
    foreach (key_set[i])
      key_set[i] = ($urandom_range(1) != 0) ? $urandom() : $urandom_range(40);
    for (int i = 0; i < n; i++)
      pending_words.push_back(make_word(
        ($urandom_range(1) != 0) ? OP_SET : OP_GET,
        ($urandom_range(99) < 85) ? key_set[$urandom_range(set_size - 1)]
                                  : $urandom(),
        $urandom()));
  endtask

  initial begin
    logic [4:0] caps[] = '{5'd1, 5'd0, 5'd31, 5'd4, 5'd17, 5'd3, 5'd2,
                           5'd8, 5'd16, 5'd5};
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    error_count = 0;
    words_taken = 0;
    send_gap    = 0;
    hold_cycles = 0;
    long_hold_done = 1'b0;
    no_idle     = 1'b0;
    shadow_count = 0;
    shadow_cap   = 5'd16;
    foreach (shadow_vld[i]) begin
      shadow_vld[i]  = 1'b0;
      shadow_rank[i] = 0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: miss on empty, extreme keys and values, hit, update, miss,
    // then fill all entries and evict the least recent.
    pending_words.push_back(make_word(OP_GET, 32'h0, 32'h0));
    pending_words.push_back(make_word(OP_SET, 32'h7fffffff, 32'h80000000));
    pending_words.push_back(make_word(OP_SET, 32'h80000000, 32'h7fffffff));
    pending_words.push_back(make_word(OP_SET, 32'hffffffff, 32'hffffffff));
    pending_words.push_back(make_word(OP_SET, 32'h0, 32'h0));
    pending_words.push_back(make_word(OP_GET, 32'h7fffffff, 32'h12345678));
    pending_words.push_back(make_word(OP_SET, 32'h80000000, 32'h00000001));
    pending_words.push_back(make_word(OP_GET, 32'h80000000, 32'h0));
    pending_words.push_back(make_word(OP_GET, 32'h00000001, 32'h0));
    for (int i = 0; i < 13; i++)
      pending_words.push_back(make_word(OP_SET, 32'h100 + i, 32'ha000 + i));
    pending_words.push_back(make_word(OP_GET, 32'hffffffff, 32'h0));
    pending_words.push_back(make_word(OP_SET, 32'h5555aaaa, 32'haaaa5555));
    pending_words.push_back(make_word(OP_GET, 32'h7fffffff, 32'h0));
    wait_idle();

    foreach (caps[p]) begin
      write_capacity(caps[p]);
      no_idle = (p == 3);
      queue_random_phase(185);
      wait_idle();
    end

    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/lkv_pkg.sv
rtl/lkv_ram.sv
rtl/lru_key_value_cache_top.sv
verif/tb_lru_key_value_cache_top.sv
